// File: src/fractional_restoring_divider_core_assert.svh
// Assertion macros used by the fractional restoring divider top level.
`ifndef FRACTIONAL_RESTORING_DIVIDER_CORE_ASSERT_SVH
`define FRACTIONAL_RESTORING_DIVIDER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/frd_pkg.sv
// Package with the types, constants and helper functions of the fractional divider.
`default_nettype none
package frd_pkg;

	localparam int FIELD_WIDTH           = 32;
	localparam int RESULT_WIDTH          = 64;
	localparam int PBITS_WIDTH           = 7;
	localparam int MAX_RESULT_BITS       = 64;
	localparam int DEFAULT_OPERAND_WIDTH = 32;
	localparam logic [PBITS_WIDTH-1:0] RESULT_BITS_RESET = 7'd24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} frd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} frd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
	} frd_status_t;

	// Mask with the low p bits set.
	function automatic logic [RESULT_WIDTH-1:0] low_ones(input logic [PBITS_WIDTH-1:0] p);
		logic [RESULT_WIDTH-1:0] m;
		for (int i = 0; i < RESULT_WIDTH; i++) begin
			m[i] = (i < int'(p));
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: src/fractional_restoring_divider_core.sv
// Top level of the fractional restoring divider: configuration register, controller, datapath.
`default_nettype none
// The divider takes an unsigned dividend and divisor (OPERAND_WIDTH bits each) when start is
// high and busy is low, and returns P = result_bits quotient bits, the integer LSB followed by
// P-1 fraction bits, right-aligned in quotient_bits. The datapath makes one quotient bit per
// cycle with a single subtract and compare, so done pulses once the RUN steps have ended (in
// the cycle after the accepting edge when the divisor or P is zero), and the next item can be
// taken in the cycle after done. The result is shown while done is high and must be taken
// then; the receiver cannot stall. result_bits is written through the cfg_valid/cfg_ready
// transfer while the block is idle and start is low; values above 64 count as 64.
module fractional_restoring_divider_core #(
	parameter int OPERAND_WIDTH = frd_pkg::DEFAULT_OPERAND_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [frd_pkg::FIELD_WIDTH-1:0]  dividend,
	input  wire logic [frd_pkg::FIELD_WIDTH-1:0]  divisor,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [frd_pkg::PBITS_WIDTH-1:0]  cfg_data,
	output logic                                  done,
	output logic [frd_pkg::RESULT_WIDTH-1:0]      quotient_bits,
	output logic                                  divide_by_zero
);
	import frd_pkg::*;

	logic [PBITS_WIDTH-1:0] result_bits_q;
	logic [PBITS_WIDTH-1:0] p_eff;
	frd_cmd_t               cmd;
	frd_status_t            status;

	// Configuration register, written by a transfer while idle with no start pending.
	assign cfg_ready = !busy && !start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_bits_q <= RESULT_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			result_bits_q <= cfg_data;
		end
	end

	// Result bits saturate at the width of the result.
	assign p_eff = (result_bits_q > PBITS_WIDTH'(MAX_RESULT_BITS))
		? PBITS_WIDTH'(MAX_RESULT_BITS) : result_bits_q;

	frd_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.p_eff  (p_eff),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	frd_dpath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dpath (
		.clk            (clk),
		.dividend       (dividend),
		.divisor        (divisor),
		.p_eff          (p_eff),
		.cmd            (cmd),
		.status         (status),
		.quotient_bits  (quotient_bits),
		.divide_by_zero (divide_by_zero)
	);

	// Checks on the sequencing and the result.
`include "fractional_restoring_divider_core_assert.svh"
	`FRD_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted item did not raise busy")
	`FRD_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done && !busy, "done strobe longer than one cycle")
	`FRD_ASSERT_SAME(a_dz_ones, clk, arst_n, done && divide_by_zero, quotient_bits == low_ones(p_eff), "zero divisor result not all ones")
	`FRD_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy && !cfg_ready, "done outside of a busy period")

endmodule
`default_nettype wire

// File: src/frd_ctrl.sv
// Controller state machine that sequences the divider steps.
`default_nettype none
module frd_ctrl #(
	parameter int OPERAND_WIDTH = frd_pkg::DEFAULT_OPERAND_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [frd_pkg::PBITS_WIDTH-1:0] p_eff,
	input  wire frd_pkg::frd_status_t           status,
	output frd_pkg::frd_cmd_t                   cmd,
	output logic                                busy,
	output logic                                done
);
	import frd_pkg::*;

	localparam int CW = $clog2(OPERAND_WIDTH + MAX_RESULT_BITS);

	frd_state_t    state_q, state_d;
	logic [CW-1:0] count_q;

	// State register and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				count_q <= CW'(OPERAND_WIDTH) + CW'(p_eff) - CW'(1);
			end else if (cmd.step) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = status.skip ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (count_q == CW'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/frd_dpath.sv
// Datapath with the partial remainder, the shifted dividend and the quotient register.
`default_nettype none
module frd_dpath #(
	parameter int OPERAND_WIDTH = frd_pkg::DEFAULT_OPERAND_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic [frd_pkg::FIELD_WIDTH-1:0]  dividend,
	input  wire logic [frd_pkg::FIELD_WIDTH-1:0]  divisor,
	input  wire logic [frd_pkg::PBITS_WIDTH-1:0]  p_eff,
	input  wire frd_pkg::frd_cmd_t                cmd,
	output frd_pkg::frd_status_t                  status,
	output logic [frd_pkg::RESULT_WIDTH-1:0]      quotient_bits,
	output logic                                  divide_by_zero
);
	import frd_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic [W+FIELD_WIDTH-1:0] a_ext, b_ext;
	logic [W-1:0]             a_w, b_w;
	logic [W-1:0]             rem_q, dvd_q, div_q;
	logic [RESULT_WIDTH-1:0]  quo_q;
	logic                     dz_q;
	logic [W+1:0]             diff;
	logic                     borrow;

	// Operands taken at the operand width: truncated or zero extended.
	assign a_ext = {{W{1'b0}}, dividend};
	assign b_ext = {{W{1'b0}}, divisor};
	assign a_w   = a_ext[W-1:0];
	assign b_w   = b_ext[W-1:0];

	// A zero divisor or zero result bits need no iteration.
	assign status.skip = (b_w == '0) || (p_eff == '0);

	// Trial subtraction of the divisor from the shifted remainder.
	assign diff   = {1'b0, rem_q, dvd_q[W-1]} - {2'b00, div_q};
	assign borrow = diff[W+1];

	// One quotient bit per step; dividend bits feed in first, then zeros.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			dvd_q <= a_w;
			div_q <= b_w;
			quo_q <= (b_w == '0) ? '1 : '0;
			dz_q  <= (b_w == '0);
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			if (!borrow) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[RESULT_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], dvd_q[W-1]};
				quo_q <= {quo_q[RESULT_WIDTH-2:0], 1'b0};
			end
		end
	end

	// Result keeps only the low P bits.
	assign quotient_bits  = quo_q & low_ones(p_eff);
	assign divide_by_zero = dz_q;

endmodule
`default_nettype wire

// File: test/tb_fractional_restoring_divider_core.sv
// Testbench of the fractional restoring divider: directed table, random phases, quotient checks.
`timescale 1ns / 100ps
module tb_fractional_restoring_divider_core;
	import frd_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 1130;
	localparam int DRAIN_CYCLES  = DEFAULT_OPERAND_WIDTH + MAX_RESULT_BITS + 8;
	localparam int IDLE_PERCENT  = 29;
	localparam int PRINT_LIMIT   = 40;

	typedef logic [FIELD_WIDTH-1:0]  operand_t;
	typedef logic [RESULT_WIDTH-1:0] qbits_t;
	typedef logic [PBITS_WIDTH-1:0]  pbits_t;

	// One expected result of the divider.
	typedef struct {
		qbits_t q;
		logic   dbz;
	} quotient_t;

	// One row of the directed table: an optional register write, then one division.
	typedef struct packed {
		logic     reconfig;
		pbits_t   bits;
		operand_t num;
		operand_t den;
		logic     fixed;
		qbits_t   q;
		logic     dbz;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 21;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// Reset width of 24 quotient bits.
		'{1'b0, 7'd0,   32'h0000_0000, 32'h0000_0000, 1'b1, 64'h0000_0000_00ff_ffff, 1'b1},
		'{1'b0, 7'd0,   32'h0000_0000, 32'h0000_0001, 1'b1, 64'h0,                   1'b0},
		'{1'b0, 7'd0,   32'h0000_0001, 32'h0000_0001, 1'b1, 64'h0000_0000_0080_0000, 1'b0},
		'{1'b0, 7'd0,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 64'h0000_0000_0080_0000, 1'b0},
		'{1'b0, 7'd0,   32'hffff_ffff, 32'h0000_0001, 1'b1, 64'h0000_0000_0080_0000, 1'b0},
		'{1'b0, 7'd0,   32'h0000_0001, 32'hffff_ffff, 1'b1, 64'h0,                   1'b0},
		'{1'b0, 7'd0,   32'h8000_0000, 32'h7fff_ffff, 1'b0, 64'h0,                   1'b0},
		'{1'b0, 7'd0,   32'h1234_5678, 32'h0000_9abc, 1'b0, 64'h0,                   1'b0},
		// A single quotient bit: only the integer LSB.
		'{1'b1, 7'd1,   32'h0000_0003, 32'h0000_0002, 1'b1, 64'h1,                   1'b0},
		'{1'b0, 7'd0,   32'h0000_0002, 32'h0000_0002, 1'b1, 64'h1,                   1'b0},
		'{1'b0, 7'd0,   32'h0000_0005, 32'h0000_0000, 1'b1, 64'h1,                   1'b1},
		// Full 64-bit result.
		'{1'b1, 7'd64,  32'h0000_0001, 32'h0000_0003, 1'b1, 64'h2aaa_aaaa_aaaa_aaaa, 1'b0},
		'{1'b0, 7'd0,   32'hffff_ffff, 32'h0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
		'{1'b0, 7'd0,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
		'{1'b0, 7'd0,   32'hdead_beef, 32'h0123_4567, 1'b0, 64'h0,                   1'b0},
		// Zero width: nothing produced, the flag still reports a zero divisor.
		'{1'b1, 7'd0,   32'h0000_0007, 32'h0000_0003, 1'b1, 64'h0,                   1'b0},
		'{1'b0, 7'd0,   32'h0000_0007, 32'h0000_0000, 1'b1, 64'h0,                   1'b1},
		// Widths above 64 saturate to 64.
		'{1'b1, 7'd127, 32'h0000_0000, 32'h0000_0000, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1},
		'{1'b0, 7'd0,   32'h0000_0001, 32'h0000_0001, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
		'{1'b1, 7'd65,  32'haaaa_aaaa, 32'h5555_5555, 1'b0, 64'h0,                   1'b0},
		'{1'b1, 7'd2,   32'h5555_5555, 32'haaaa_aaaa, 1'b0, 64'h0,                   1'b0}
	};

	// Widths that the random phases start with before going fully random.
	localparam int EDGE_COUNT = 7;
	localparam pbits_t EDGE_BITS [EDGE_COUNT] = '{7'd24, 7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd32};

	logic     clk;
	logic     arst_n     = 1'b0;
	logic     start      = 1'b0;
	operand_t dividend   = '0;
	operand_t divisor    = '0;
	logic     cfg_valid  = 1'b0;
	pbits_t   cfg_data   = '0;
	logic     busy;
	logic     cfg_ready;
	logic     done;
	qbits_t   quotient_bits;
	logic     divide_by_zero;

	// Table-typed expectation that travels with the item on the bus.
	logic     table_fixed = 1'b0;
	qbits_t   table_q     = '0;
	logic     table_dbz   = 1'b0;

	quotient_t quotient_fifo [$];
	pbits_t    model_bits     = RESULT_BITS_RESET;
	bit        gaps_on        = 1'b1;
	int        error_count    = 0;
	int        items_taken    = 0;
	int        results_seen   = 0;
	int        zero_divisors  = 0;
	int        bit_writes     = 0;
	int        cycle_count    = 0;

	fractional_restoring_divider_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.dividend       (dividend),
		.divisor        (divisor),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.quotient_bits  (quotient_bits),
		.divide_by_zero (divide_by_zero)
	);

	// Clock and a single reset pulse at the start of the run.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the block hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results pending", CYCLE_LIMIT,
			quotient_fifo.size());
		$display("fractional_restoring_divider_core verification failed");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Restoring long division: the integer LSB, then one fraction bit per step.
	function automatic quotient_t fraction_quotient(input operand_t num, input operand_t den,
			input pbits_t bits_reg);
		quotient_t res;
		int        nbits;
		qbits_t    mask;
		logic [RESULT_WIDTH:0] rem;
		nbits = (int'(bits_reg) > MAX_RESULT_BITS) ? MAX_RESULT_BITS : int'(bits_reg);
		mask = (nbits == 0) ? '0 : ({RESULT_WIDTH{1'b1}} >> (RESULT_WIDTH - nbits));
		res.q = '0;
		res.dbz = (den == '0);
		if (res.dbz) begin
			res.q = mask;
		end else if (nbits > 0) begin
			res.q = qbits_t'(num / den) & qbits_t'(1);
			rem = (RESULT_WIDTH+1)'(num % den);
			for (int i = 1; i < nbits; i++) begin
				rem = rem << 1;
				if (rem >= (RESULT_WIDTH+1)'(den)) begin
					rem = rem - (RESULT_WIDTH+1)'(den);
					res.q = {res.q[RESULT_WIDTH-2:0], 1'b1};
				end else begin
					res.q = {res.q[RESULT_WIDTH-2:0], 1'b0};
				end
			end
			res.q = res.q & mask;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input qbits_t got, input qbits_t want);
		if (error_count < PRINT_LIMIT) begin
			$display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
		end
		error_count++;
	endtask

	// Watch every transfer on the bus and check each result against the oldest expectation.
	always @(posedge clk) begin : monitor
		quotient_t want;
		if (arst_n) begin
			if (start && !busy) begin
				if (table_fixed) begin
					want.q = table_q;
					want.dbz = table_dbz;
				end else begin
					want = fraction_quotient(dividend, divisor, model_bits);
				end
				quotient_fifo = {quotient_fifo, want};
				items_taken++;
				if (divisor == '0) begin
					zero_divisors++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				model_bits = cfg_data;
				bit_writes++;
			end
			if (done) begin
				results_seen++;
				if (quotient_fifo.size() == 0) begin
					report_mismatch("result with nothing pending", quotient_bits, '0);
				end else begin
					want = quotient_fifo.pop_front();
					if (quotient_bits !== want.q) begin
						report_mismatch("quotient_bits", quotient_bits, want.q);
					end
					if (divide_by_zero !== want.dbz) begin
						report_mismatch("divide_by_zero", qbits_t'(divide_by_zero),
							qbits_t'(want.dbz));
					end
				end
			end
		end
	end

	// Wait until every expected result has come back; the check is made away from the edge.
	task automatic drain_results();
		do begin
			@(negedge clk);
		end while (quotient_fifo.size() != 0);
		@(posedge clk);
	endtask

	// Write the width register once the block has gone idle.
	task automatic set_result_bits(input pbits_t value);
		start <= 1'b0;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Present one division and hold it until the block takes it.
	task automatic send_division(input operand_t num, input operand_t den, input logic fixed,
			input qbits_t q_fixed, input logic dbz_fixed);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		dividend <= num;
		divisor <= den;
		table_fixed <= fixed;
		table_q <= q_fixed;
		table_dbz <= dbz_fixed;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	// Operands weighted toward zero, all ones, small values and single set bits.
	function automatic operand_t pick_operand();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return '1;
			2: return operand_t'($urandom_range(1, 255));
			3: return operand_t'(1) << $urandom_range(0, FIELD_WIDTH - 1);
			4: return operand_t'($urandom) >> $urandom_range(0, FIELD_WIDTH - 1);
			default: return operand_t'($urandom);
		endcase
	endfunction

	// Mostly legal widths, with zero and saturating values now and then.
	function automatic pbits_t pick_bits();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			return '0;
		end else if (roll == 1) begin
			return pbits_t'($urandom_range(MAX_RESULT_BITS + 1, 127));
		end
		return pbits_t'($urandom_range(1, MAX_RESULT_BITS));
	endfunction

	// Stimulus: the directed table first, then random phases at changing widths.
	initial begin : stimulus
		operand_t num;
		operand_t den;
		pbits_t   bits;
		int       phase;
		int       phase_len;
		int       random_sent;
		phase = 0;
		random_sent = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].reconfig) begin
				set_result_bits(DIRECTED_ROWS[r].bits);
			end
			send_division(DIRECTED_ROWS[r].num, DIRECTED_ROWS[r].den, DIRECTED_ROWS[r].fixed,
				DIRECTED_ROWS[r].q, DIRECTED_ROWS[r].dbz);
		end

		while (random_sent < RANDOM_ITEMS) begin
			bits = (phase < EDGE_COUNT) ? EDGE_BITS[phase] : pick_bits();
			set_result_bits(bits);
			// The full-width phase runs back to back with no idling.
			gaps_on = (phase != 1);
			phase_len = (phase == 1) ? 200 : $urandom_range(30, 110);
			if (phase_len > RANDOM_ITEMS - random_sent) begin
				phase_len = RANDOM_ITEMS - random_sent;
			end
			repeat (phase_len) begin
				den = pick_operand();
				num = pick_operand();
				if ($urandom_range(0, 6) == 0) begin
					num = den + operand_t'($urandom_range(0, 2)) - operand_t'(1);
				end
				send_division(num, den, 1'b0, '0, 1'b0);
				random_sent++;
			end
			phase++;
		end

		start <= 1'b0;
		table_fixed <= 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d divisions (%0d by zero) over %0d width settings in %0d cycles.",
			items_taken, zero_divisors, bit_writes + 1, cycle_count);
		$display("Checked %0d results; %0d mismatches, %0d still pending.",
			results_seen, error_count, quotient_fifo.size());
		if (error_count == 0 && quotient_fifo.size() == 0) begin
			$display("fractional_restoring_divider_core verification clean");
		end else begin
			$display("fractional_restoring_divider_core verification failed");
		end
		$finish;
	end

endmodule
